FILE: hdl/sda_pkg.sv
`timescale 1ns / 1ps
// types, codes and constants for the scaled decimal alu
// no dependencies
package sda_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int PREC_LSB  = 59;
    localparam int PREC_W    = 4;
    localparam int DIV_STEPS = 64;
    localparam int MUL_STEPS = 15;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NE  = 3'd5
    } op_t;

    // input register stage
    typedef struct packed {
        logic              valid;
        logic [2:0]        op;
        logic [WORD_W-1:0] a_word;
        logic [WORD_W-1:0] b_word;
    } in_stage_t;

    // partial products and operand selection
    typedef struct packed {
        logic              valid;
        logic [2:0]        op;
        logic [WORD_W-1:0] a_word;
        logic [WORD_W-1:0] p_lo;
        logic [HALF_W-1:0] p_x1;
        logic [HALF_W-1:0] p_x2;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
        logic [PREC_W-1:0] mcnt;
        logic              dz;
    } pp_stage_t;

    // divider and scaling stages
    typedef struct packed {
        logic              valid;
        logic [2:0]        op;
        logic [WORD_W-1:0] a_word;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] den;
        logic              neg;
        logic [PREC_W-1:0] mcnt;
        logic              dz;
    } pipe_t;

    function automatic logic [WORD_W-1:0] pow10(input logic [PREC_W-1:0] n);
        logic [WORD_W-1:0] r;
        case (n)
            4'd0:    r = 64'd1;
            4'd1:    r = 64'd10;
            4'd2:    r = 64'd100;
            4'd3:    r = 64'd1000;
            4'd4:    r = 64'd10000;
            4'd5:    r = 64'd100000;
            4'd6:    r = 64'd1000000;
            4'd7:    r = 64'd10000000;
            4'd8:    r = 64'd100000000;
            4'd9:    r = 64'd1000000000;
            4'd10:   r = 64'd10000000000;
            4'd11:   r = 64'd100000000000;
            4'd12:   r = 64'd1000000000000;
            4'd13:   r = 64'd10000000000000;
            4'd14:   r = 64'd100000000000000;
            default: r = 64'd1000000000000000;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] raw_of(input logic [WORD_W-1:0] w);
        return {w[WORD_W-1], {PREC_W{w[WORD_W-1]}}, w[PREC_LSB-1:0]};
    endfunction

    function automatic logic [WORD_W-1:0] pack(input logic [WORD_W-1:0] v,
                                               input logic [PREC_W-1:0] p);
        return {v[WORD_W-1], p, v[PREC_LSB-1:0]};
    endfunction

endpackage

FILE: hdl/scaled_decimal_alu_unit.sv
`timescale 1ns / 1ps
// scaled decimal alu: add, subtract, multiply, divide and compare on packed decimals
// depends on sda_pkg
// pipeline: the same path for every operation, set by the 64 divider stages,
//   the 15 times-ten stages and six other register stages
// throughput: one beat per cycle when not stalled, every stage fully pipelined
// backpressure stalls the whole pipeline; s_tready follows m_tready or an empty output
// reset (aresetn low, synchronous) clears all valid bits; data registers are not reset
module scaled_decimal_alu_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_word, b_word
    input  logic [2:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_word
    output logic [1:0]   m_tuser    // compare_true, status
);

    localparam int W  = sda_pkg::WORD_W;
    localparam int PW = sda_pkg::PREC_W;
    localparam int PL = sda_pkg::PREC_LSB;
    localparam int HW = sda_pkg::HALF_W;
    localparam int ND = sda_pkg::DIV_STEPS;
    localparam int NM = sda_pkg::MUL_STEPS;

    logic adv;

    sda_pkg::in_stage_t in_reg, in_next;
    sda_pkg::pp_stage_t pp_reg, pp_next;
    sda_pkg::pipe_t     sum_reg, sum_next;
    sda_pkg::pipe_t     div_reg [1:ND];
    sda_pkg::pipe_t     div_next [1:ND];
    sda_pkg::pipe_t     sgn_reg, sgn_next;
    sda_pkg::pipe_t     mul_reg [1:NM];
    sda_pkg::pipe_t     mul_next [1:NM];

    logic          out_valid_reg;
    logic [W-1:0]  out_word_reg, out_word_next;
    logic          out_cmp_reg, out_cmp_next;
    logic          out_st_reg, out_st_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = {out_st_reg, out_cmp_reg};

    // input register
    always_comb begin
        in_next.valid  = s_tvalid;
        in_next.op     = s_tuser;
        in_next.a_word = s_tdata[W-1:0];
        in_next.b_word = s_tdata[2*W-1:W];
    end

    // partial products, divisor and scale count selection
    always_comb begin
        logic [W-1:0]  ra, rb;
        logic [PW-1:0] pa, pb;
        ra = sda_pkg::raw_of(in_reg.a_word);
        rb = sda_pkg::raw_of(in_reg.b_word);
        pa = in_reg.a_word[PL +: PW];
        pb = in_reg.b_word[PL +: PW];
        pp_next.valid  = in_reg.valid;
        pp_next.op     = in_reg.op;
        pp_next.a_word = in_reg.a_word;
        pp_next.p_lo   = {{HW{1'b0}}, ra[HW-1:0]} * {{HW{1'b0}}, rb[HW-1:0]};
        pp_next.p_x1   = HW'(ra[HW-1:0] * rb[W-1:HW]);
        pp_next.p_x2   = HW'(ra[W-1:HW] * rb[HW-1:0]);
        pp_next.num    = rb;
        pp_next.den    = sda_pkg::pow10((pb > pa) ? PW'(pb - pa) : '0);
        pp_next.mcnt   = (pa > pb) ? PW'(pa - pb) : '0;
        pp_next.dz     = 1'b0;
        case (in_reg.op)
            sda_pkg::OP_MUL: begin
                pp_next.den  = sda_pkg::pow10(pb);
                pp_next.mcnt = '0;
            end
            sda_pkg::OP_DIV: begin
                pp_next.num  = ra;
                pp_next.den  = rb;
                pp_next.mcnt = pb;
                pp_next.dz   = (rb == '0);
            end
            default: begin
            end
        endcase
    end

    // product assembly
    always_comb begin
        sum_next.valid  = pp_reg.valid;
        sum_next.op     = pp_reg.op;
        sum_next.a_word = pp_reg.a_word;
        sum_next.rem    = '0;
        sum_next.quo    = (pp_reg.op == sda_pkg::OP_MUL)
                          ? pp_reg.p_lo + {pp_reg.p_x1 + pp_reg.p_x2, {HW{1'b0}}}
                          : pp_reg.num;
        sum_next.den    = pp_reg.den;
        sum_next.neg    = 1'b0;
        sum_next.mcnt   = pp_reg.mcnt;
        sum_next.dz     = pp_reg.dz;
    end

    // magnitudes and quotient sign
    sda_pkg::pipe_t mag_reg, mag_next;

    always_comb begin
        mag_next      = sum_reg;
        mag_next.rem  = '0;
        mag_next.quo  = sum_reg.quo[W-1] ? W'(-sum_reg.quo) : sum_reg.quo;
        mag_next.den  = sum_reg.den[W-1] ? W'(-sum_reg.den) : sum_reg.den;
        mag_next.neg  = sum_reg.quo[W-1] ^ sum_reg.den[W-1];
    end

    // restoring divider, one quotient bit per stage
    genvar gi;
    generate
        for (gi = 0; gi < ND; gi++) begin : g_div
            sda_pkg::pipe_t src;
            if (gi == 0) begin : g_first
                assign src = mag_reg;
            end else begin : g_rest
                assign src = div_reg[gi];
            end
            always_comb begin
                logic [W:0] t;
                logic [W:0] d;
                logic       ge;
                t   = {src.rem, src.quo[W-1]};
                d   = {1'b0, src.den};
                ge  = (t >= d);
                div_next[gi+1]     = src;
                div_next[gi+1].rem = ge ? W'(t - d) : t[W-1:0];
                div_next[gi+1].quo = {src.quo[W-2:0], ge};
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    div_reg[gi+1].valid <= 1'b0;
                end else if (adv) begin
                    div_reg[gi+1] <= div_next[gi+1];
                end
            end
        end
    endgenerate

    // apply quotient sign
    always_comb begin
        sgn_next     = div_reg[ND];
        sgn_next.quo = div_reg[ND].neg ? W'(-div_reg[ND].quo) : div_reg[ND].quo;
    end

    // times ten, one digit per stage
    generate
        for (gi = 0; gi < NM; gi++) begin : g_mul
            sda_pkg::pipe_t src;
            if (gi == 0) begin : g_first
                assign src = sgn_reg;
            end else begin : g_rest
                assign src = mul_reg[gi];
            end
            always_comb begin
                mul_next[gi+1] = src;
                if (src.mcnt != '0) begin
                    mul_next[gi+1].quo  = {src.quo[W-4:0], 3'b000}
                                        + {src.quo[W-2:0], 1'b0};
                    mul_next[gi+1].mcnt = src.mcnt - PW'(1);
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    mul_reg[gi+1].valid <= 1'b0;
                end else if (adv) begin
                    mul_reg[gi+1] <= mul_next[gi+1];
                end
            end
        end
    endgenerate

    // final operation and repack
    always_comb begin
        logic [W-1:0]  ra;
        logic [W-1:0]  v;
        logic [PW-1:0] pa;
        ra            = sda_pkg::raw_of(mul_reg[NM].a_word);
        v             = mul_reg[NM].quo;
        pa            = mul_reg[NM].a_word[PL +: PW];
        out_word_next = mul_reg[NM].a_word;
        out_cmp_next  = 1'b0;
        out_st_next   = 1'b0;
        case (mul_reg[NM].op)
            sda_pkg::OP_ADD: out_word_next = sda_pkg::pack(ra + v, pa);
            sda_pkg::OP_SUB: out_word_next = sda_pkg::pack(ra - v, pa);
            sda_pkg::OP_MUL: out_word_next = sda_pkg::pack(v, pa);
            sda_pkg::OP_DIV: begin
                out_word_next = sda_pkg::pack(mul_reg[NM].dz ? '0 : v, pa);
                out_st_next   = mul_reg[NM].dz;
            end
            sda_pkg::OP_EQ:  out_cmp_next = (ra == v);
            sda_pkg::OP_NE:  out_cmp_next = (ra != v);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid  <= 1'b0;
            pp_reg.valid  <= 1'b0;
            sum_reg.valid <= 1'b0;
            mag_reg.valid <= 1'b0;
            sgn_reg.valid <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            in_reg        <= in_next;
            pp_reg        <= pp_next;
            sum_reg       <= sum_next;
            mag_reg       <= mag_next;
            sgn_reg       <= sgn_next;
            out_valid_reg <= mul_reg[NM].valid;
            out_word_reg  <= out_word_next;
            out_cmp_reg   <= out_cmp_next;
            out_st_reg    <= out_st_next;
        end
    end

endmodule

FILE: test/tb_scaled_decimal_alu_unit.sv
`timescale 1ns / 1ps
// self-checking bench for scaled_decimal_alu_unit: directed corners then random beats,
// predicted results compared per field. depends on sda_pkg and the unit itself
module tb_scaled_decimal_alu_unit;

    typedef struct packed {
        logic [63:0] word;
        logic        cmp;
        logic        st;
    } alu_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    alu_result_t pending_q[$];
    int          errors = 0;
    int          results_seen = 0;
    int          beats_sent = 0;
    longint      cycle_count = 0;
    bit          hold_off = 1'b0;
    bit          rx_gaps = 1'b1;

    always #10 aclk = ~aclk;

    scaled_decimal_alu_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic logic [63:0] sign_ext_raw(input logic [63:0] w);
        return {{5{w[63]}}, w[58:0]};
    endfunction

    function automatic logic [63:0] repack(input logic [63:0] v, input logic [3:0] p);
        return {v[63], p, v[58:0]};
    endfunction

    function automatic logic [63:0] trunc_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] scale_up(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) v = v * 64'd10;
        return v;
    endfunction

    function automatic logic [63:0] scale_down(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) v = trunc_div(v, 64'd10);
        return v;
    endfunction

    function automatic logic [63:0] align_b(input logic [63:0] a, input logic [63:0] b);
        int pa, pb;
        pa = int'(a[62:59]);
        pb = int'(b[62:59]);
        if (pa > pb) return scale_up(sign_ext_raw(b), pa - pb);
        return scale_down(sign_ext_raw(b), pb - pa);
    endfunction

    function automatic alu_result_t decimal_result(input logic [2:0] op,
                                                   input logic [63:0] a,
                                                   input logic [63:0] b);
        alu_result_t r;
        logic [63:0] ra, rb;
        ra = sign_ext_raw(a);
        rb = sign_ext_raw(b);
        r = '{word: a, cmp: 1'b0, st: 1'b0};
        case (op)
            sda_pkg::OP_ADD: r.word = repack(ra + align_b(a, b), a[62:59]);
            sda_pkg::OP_SUB: r.word = repack(ra - align_b(a, b), a[62:59]);
            sda_pkg::OP_MUL: r.word = repack(scale_down(ra * rb, int'(b[62:59])), a[62:59]);
            sda_pkg::OP_DIV: begin
                if (rb == '0) begin
                    r.word = repack('0, a[62:59]);
                    r.st = 1'b1;
                end else begin
                    r.word = repack(scale_up(trunc_div(ra, rb), int'(b[62:59])), a[62:59]);
                end
            end
            sda_pkg::OP_EQ: r.cmp = (ra == align_b(a, b));
            sda_pkg::OP_NE: r.cmp = (ra != align_b(a, b));
            default: ;
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        int k;
        w = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        if (k < 4) w[58:0] = (w[63] ? {59{1'b1}} : 59'd0) ^ 59'($urandom_range(0, 99999));
        else if (k == 4) w[58:0] = w[63] ? '0 : '1;
        return w;
    endfunction

    task automatic send_beat(input logic [2:0] op, input logic [63:0] a, input logic [63:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_q.push_back(decimal_result(op, a, b));
        beats_sent++;
    endtask

    // receiver side
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            alu_result_t exp_r;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_r = pending_q.pop_front();
                results_seen++;
                if (m_tdata !== exp_r.word) begin
                    $error("result_word exp %h got %h", exp_r.word, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== exp_r.cmp) begin
                    $error("compare_true exp %b got %b", exp_r.cmp, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== exp_r.st) begin
                    $error("status exp %b got %b", exp_r.st, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int g;
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                g = gap_len() + 1;
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_000_000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        logic [63:0] big, neg1, p15;
        big = {1'b0, 4'd0, {59{1'b1}}};
        neg1 = '1 & ~(64'hF << 59);
        p15 = {1'b0, 4'd15, 59'd0};
        for (int op = 0; op < 8; op++) begin
            send_beat(3'(op), {1'b0, 4'd2, 59'd12345}, {1'b0, 4'd0, 59'd7});
        end
        send_beat(sda_pkg::OP_ADD, big, big);
        send_beat(sda_pkg::OP_SUB, {1'b1, 4'd0, 59'd0}, big);
        send_beat(sda_pkg::OP_MUL, big, big | p15);
        send_beat(sda_pkg::OP_MUL, neg1 | p15, {1'b1, 4'd15, 59'd5});
        send_beat(sda_pkg::OP_DIV, {1'b0, 4'd3, 59'd999}, {1'b0, 4'd9, 59'd0});
        send_beat(sda_pkg::OP_DIV, {1'b1, 4'd7, 59'd100}, {1'b0, 4'd9, 59'd0});
        send_beat(sda_pkg::OP_DIV, {1'b1, 4'd0, 59'd0}, neg1);
        send_beat(sda_pkg::OP_DIV, big, {1'b0, 4'd15, 59'd3});
        send_beat(sda_pkg::OP_EQ, {1'b0, 4'd2, 59'd500}, {1'b0, 4'd0, 59'd5});
        send_beat(sda_pkg::OP_NE, {1'b0, 4'd0, 59'd5}, {1'b0, 4'd3, 59'd5999});
        send_beat(sda_pkg::OP_EQ, {1'b1, 4'd15, ~59'd0}, {1'b1, 4'd0, ~59'd0});
        send_beat(sda_pkg::OP_ADD, '1, '1);
        send_beat(sda_pkg::OP_SUB, '0, '0);
    endtask

    task automatic test_random(input int n);
        logic [2:0] op;
        logic [63:0] a, b;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            a = rand_word();
            b = rand_word();
            if (op == sda_pkg::OP_EQ && $urandom_range(0, 1)) b = a;
            send_beat(op, a, b);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(150);
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(700);
        test_backpressure();
        rx_gaps = 1'b0;
        test_random(300);
        rx_gaps = 1'b1;
        test_random(550);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("sent %0d beats, checked %0d results over all operations,", beats_sent, results_seen);
        $display("including zero divisors, wrap-around and a long output stall");
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
